FILE: rtl/core/odaf_pkg.sv
// Shared types and constants for the occlusion driven alpha fader.
`default_nettype none
package odaf_pkg;

    localparam int ALPHA_W  = 17;
    localparam int COUNT_W  = 32;
    localparam int TD_W     = 16;
    localparam int CFG_W    = 24;
    localparam int SPEED_W  = 26;
    localparam int IDX_W    = 3;
    localparam int FADE_W   = 5;
    localparam int PROD_W   = COUNT_W + TD_W;
    localparam int DIV_W    = 38;
    localparam int DIV_STEPS = ALPHA_W;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE    = 17'd65536;
    localparam logic [COUNT_W-1:0] SAMPLE_FLOOR = 32'd15;
    localparam logic [COUNT_W-1:0] FADE_KNEE    = 32'd45;
    localparam logic [FADE_W-1:0]  SAMPLE_SPAN  = 5'd30;
    localparam logic [CFG_W-1:0]   CFG_RESET_RATE = 24'd65536;

    typedef enum logic [IDX_W-1:0] {
        REG_MULTI_QUERIES = 3'd0,
        REG_IN_MAX_SPEED  = 3'd1,
        REG_IN_ACCEL      = 3'd2,
        REG_OUT_MAX_SPEED = 3'd3,
        REG_OUT_ACCEL     = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        PH_OFF        = 2'b00,
        PH_PENDING    = 2'b01,
        PH_AWAIT_FULL = 2'b10,
        PH_AWAIT_PART = 2'b11
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GNUM,
        S_GDEN,
        S_GSTART,
        S_GDIV,
        S_SCHK,
        S_SMAG,
        S_SMOVE,
        S_SAPPLY,
        S_DONE
    } state_t;

    typedef struct packed {
        logic draw;
        logic rearm;
        logic visible;
        logic full_pass;
        logic multi;
    } phase_ctl_t;

    typedef struct packed {
        logic granted;
        logic is_full;
    } grant_t;

endpackage
`default_nettype wire

FILE: rtl/core/odaf_ifs.sv
// Handshake channel interfaces: input items, results and register writes.
`default_nettype none
interface odaf_item_if;
    logic                          valid;
    logic                          ready;
    logic                          cmd;
    logic                          full_pass;
    logic                          visible;
    logic                          results_ready;
    logic [odaf_pkg::COUNT_W-1:0]  full_count;
    logic [odaf_pkg::COUNT_W-1:0]  part_count;
    logic [odaf_pkg::TD_W-1:0]     time_delta;

    modport source (output valid, cmd, full_pass, visible, results_ready,
                    full_count, part_count, time_delta, input ready);
    modport sink (input valid, cmd, full_pass, visible, results_ready,
                  full_count, part_count, time_delta, output ready);
endinterface

interface odaf_result_if;
    logic                          valid;
    logic                          ready;
    logic                          query_granted;
    logic                          query_is_full;
    logic [odaf_pkg::ALPHA_W-1:0]  current_alpha;
    logic [odaf_pkg::ALPHA_W-1:0]  target_alpha;

    modport source (output valid, query_granted, query_is_full, current_alpha,
                    target_alpha, input ready);
    modport sink (input valid, query_granted, query_is_full, current_alpha,
                  target_alpha, output ready);
endinterface

interface odaf_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [odaf_pkg::IDX_W-1:0]    index;
    logic [odaf_pkg::CFG_W-1:0]    wdata;

    modport source (output valid, index, wdata, input ready);
    modport sink (input valid, index, wdata, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/odaf_phase.sv
// Occlusion test phase register and query grant logic.
`default_nettype none
module odaf_phase (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire odaf_pkg::phase_ctl_t ctl,
    output odaf_pkg::phase_t         phase,
    output odaf_pkg::grant_t         grant
);

    odaf_pkg::phase_t phase_reg;
    odaf_pkg::phase_t phase_next;
    odaf_pkg::phase_t vis_phase;
    odaf_pkg::phase_t draw_phase;
    logic             granted;

    always_comb
    begin
        if (ctl.visible)
        begin
            vis_phase = (phase_reg == odaf_pkg::PH_OFF) ? odaf_pkg::PH_AWAIT_FULL : phase_reg;
        end
        else
        begin
            vis_phase = odaf_pkg::PH_OFF;
        end

        draw_phase = vis_phase;
        granted    = 1'b0;
        if (ctl.multi)
        begin
            if (vis_phase != odaf_pkg::PH_OFF)
            begin
                draw_phase = odaf_pkg::PH_PENDING;
                granted    = 1'b1;
            end
        end
        else
        begin
            case (vis_phase)
                odaf_pkg::PH_AWAIT_FULL:
                begin
                    draw_phase = odaf_pkg::PH_AWAIT_PART;
                    granted    = 1'b1;
                end
                odaf_pkg::PH_AWAIT_PART:
                begin
                    draw_phase = odaf_pkg::PH_PENDING;
                    granted    = 1'b1;
                end
                default:
                begin
                    draw_phase = vis_phase;
                end
            endcase
        end

        grant.granted = granted;
        grant.is_full = granted & ctl.full_pass;

        if (ctl.draw)
        begin
            phase_next = draw_phase;
        end
        else if (ctl.rearm)
        begin
            phase_next = odaf_pkg::PH_AWAIT_FULL;
        end
        else
        begin
            phase_next = phase_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= odaf_pkg::PH_AWAIT_FULL;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

    assign phase = phase_reg;

endmodule
`default_nettype wire

FILE: rtl/core/odaf_mul.sv
// Shared 32x16 multiplier with registered product.
`default_nettype none
module odaf_mul (
    input  wire logic                          clk,
    input  wire logic                          en,
    input  wire logic [odaf_pkg::COUNT_W-1:0]  a,
    input  wire logic [odaf_pkg::TD_W-1:0]     b,
    output logic [odaf_pkg::PROD_W-1:0]        p
);

    logic [odaf_pkg::PROD_W-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= odaf_pkg::PROD_W'(a) * odaf_pkg::PROD_W'(b);
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

FILE: rtl/core/odaf_div.sv
// Iterative restoring divider, one quotient bit per cycle, quotient of a fraction <= 1.
`default_nettype none
module odaf_div (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [odaf_pkg::DIV_W-1:0]    num,
    input  wire logic [odaf_pkg::DIV_W-1:0]    den,
    output logic                               done,
    output logic [odaf_pkg::ALPHA_W-1:0]       quot
);

    localparam int CNT_W = $clog2(odaf_pkg::DIV_STEPS);
    localparam logic [CNT_W-1:0] LAST = CNT_W'(odaf_pkg::DIV_STEPS - 1);

    logic                          busy_reg;
    logic                          done_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [odaf_pkg::DIV_W-1:0]    rem_reg;
    logic [odaf_pkg::DIV_W-1:0]    den_reg;
    logic [odaf_pkg::ALPHA_W-1:0]  quot_reg;
    logic [odaf_pkg::DIV_W-1:0]    trial;
    logic                          qbit;

    always_comb
    begin
        trial = (cnt_reg == '0) ? rem_reg : {rem_reg[odaf_pkg::DIV_W-2:0], 1'b0};
        qbit  = (trial >= den_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == LAST)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= num;
            den_reg  <= den;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= qbit ? (trial - den_reg) : trial;
            quot_reg <= {quot_reg[odaf_pkg::ALPHA_W-2:0], qbit};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
`default_nettype wire

FILE: rtl/core/occlusion_driven_alpha_fader.sv
// Flare alpha fader top level: sequencer, fade state, registers and result stage.
//
// Channels: item (sink) takes draw-pass (cmd=0) and frame-update (cmd=1) items,
// result (source) returns exactly one result per item, cfg (sink) writes the
// five control registers by index and is always ready; writes to unknown
// indexes are dropped. Write registers only while no item is in flight.
// A transfer on any channel happens when valid and ready are both high.
// A draw pass goes from idle straight to the result stage. An update runs the
// speed and position steps of the fade; one that computes a new target first
// runs the 17-step restoring divider. The shared 32x16 multiplier serves both
// the target ratio setup and the speed and position steps of the fade.
// item.ready is high only while the sequencer is idle, so one item is worked
// on at a time: a new item is taken only after the last result is loaded. The
// result register lets the next item be taken while a result still waits;
// a finished item then holds in its last state until the result register
// frees up.
// Reset: alpha, target and speed are zero, the phase awaits the full query,
// multiple-query mode is off and all speeds and accelerations are 1.0.
`default_nettype none
module occlusion_driven_alpha_fader (
    input  wire logic     clk,
    input  wire logic     rst_n,
    odaf_item_if.sink     item,
    odaf_result_if.source result,
    odaf_cfg_if.sink      cfg
);

    localparam int AW = odaf_pkg::ALPHA_W;
    localparam int CW = odaf_pkg::CFG_W;
    localparam int SW = odaf_pkg::SPEED_W;

    odaf_pkg::state_t     state_reg;
    odaf_pkg::state_t     state_next;
    odaf_pkg::phase_t     phase;
    odaf_pkg::grant_t     grant;
    odaf_pkg::phase_ctl_t phase_ctl;

    logic          multi_reg;
    logic [CW-1:0] in_max_reg;
    logic [CW-1:0] in_acc_reg;
    logic [CW-1:0] out_max_reg;
    logic [CW-1:0] out_acc_reg;

    logic [AW-1:0] now_reg;
    logic [AW-1:0] goal_reg;
    logic [SW-1:0] speed_reg;
    logic [CW-1:0] mag_reg;

    logic [odaf_pkg::COUNT_W-1:0] full_reg;
    logic [odaf_pkg::COUNT_W-1:0] part_reg;
    logic [odaf_pkg::TD_W-1:0]    td_reg;
    logic [odaf_pkg::DIV_W-1:0]   n_reg;
    logic                         gr_reg;
    logic                         gr_full_reg;

    logic          res_valid_reg;
    logic          res_granted_reg;
    logic          res_full_reg;
    logic [AW-1:0] res_now_reg;
    logic [AW-1:0] res_goal_reg;

    logic                          accept;
    logic                          goal_calc;
    logic                          counts_ok;
    logic                          load_res;
    logic                          up;
    logic                          mul_en;
    logic [odaf_pkg::COUNT_W-1:0]  mul_a;
    logic [odaf_pkg::TD_W-1:0]     mul_b;
    logic [odaf_pkg::PROD_W-1:0]   mul_p;
    logic                          div_start;
    logic                          div_done;
    logic [AW-1:0]                 div_quot;
    logic [odaf_pkg::COUNT_W-1:0]  ratio_num;
    logic [odaf_pkg::FADE_W-1:0]   fade;
    logic [CW-1:0]                 step;
    logic [CW-1:0]                 base;
    logic [CW-1:0]                 max_sel;
    logic [CW-1:0]                 acc_sel;
    logic [CW:0]                   mag_sum;
    logic [CW-1:0]                 mag_new;
    logic [SW-1:0]                 speed_neg;
    logic [AW-1:0]                 diff;
    logic [CW-1:0]                 move;

    assign accept    = item.valid && item.ready;
    assign item.ready = (state_reg == odaf_pkg::S_IDLE);
    assign cfg.ready = 1'b1;

    assign goal_calc = (phase == odaf_pkg::PH_PENDING) && item.results_ready;
    assign counts_ok = (item.full_count > odaf_pkg::SAMPLE_FLOOR) &&
                       (item.part_count > odaf_pkg::SAMPLE_FLOOR);

    always_comb
    begin
        phase_ctl.draw      = accept && !item.cmd;
        phase_ctl.rearm     = accept && item.cmd && goal_calc && !multi_reg;
        phase_ctl.visible   = item.visible;
        phase_ctl.full_pass = item.full_pass;
        phase_ctl.multi     = multi_reg;
    end

    odaf_phase u_phase (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (phase_ctl),
        .phase (phase),
        .grant (grant)
    );

    odaf_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    odaf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (n_reg),
        .den   (mul_p[odaf_pkg::DIV_W-1:0]),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Fade datapath
    always_comb
    begin
        ratio_num = (part_reg < full_reg) ? part_reg : full_reg;
        fade      = (full_reg >= odaf_pkg::FADE_KNEE) ? odaf_pkg::SAMPLE_SPAN :
                    odaf_pkg::FADE_W'(full_reg - odaf_pkg::SAMPLE_FLOOR);
        up        = (goal_reg > now_reg);
        speed_neg = -speed_reg;
        max_sel   = up ? in_max_reg : out_max_reg;
        acc_sel   = up ? in_acc_reg : out_acc_reg;
        if (up)
        begin
            base = speed_reg[SW-1] ? '0 : speed_reg[CW-1:0];
        end
        else
        begin
            base = speed_reg[SW-1] ? speed_neg[CW-1:0] : '0;
        end
        step    = mul_p[CW+15:16];
        mag_sum = {1'b0, base} + {1'b0, step};
        mag_new = (mag_sum > {1'b0, max_sel}) ? max_sel : mag_sum[CW-1:0];
        diff    = up ? (goal_reg - now_reg) : (now_reg - goal_reg);
        move    = mul_p[CW+15:16];
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        mul_en     = 1'b0;
        mul_a      = '0;
        mul_b      = '0;
        div_start  = 1'b0;
        load_res   = 1'b0;
        case (state_reg)
            odaf_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    if (!item.cmd)
                    begin
                        state_next = odaf_pkg::S_DONE;
                    end
                    else if (goal_calc && counts_ok)
                    begin
                        state_next = odaf_pkg::S_GNUM;
                    end
                    else
                    begin
                        state_next = odaf_pkg::S_SCHK;
                    end
                end
            end
            odaf_pkg::S_GNUM:
            begin
                mul_en     = 1'b1;
                mul_a      = ratio_num;
                mul_b      = odaf_pkg::TD_W'(fade);
                state_next = odaf_pkg::S_GDEN;
            end
            odaf_pkg::S_GDEN:
            begin
                mul_en     = 1'b1;
                mul_a      = full_reg;
                mul_b      = odaf_pkg::TD_W'(odaf_pkg::SAMPLE_SPAN);
                state_next = odaf_pkg::S_GSTART;
            end
            odaf_pkg::S_GSTART:
            begin
                div_start  = 1'b1;
                state_next = odaf_pkg::S_GDIV;
            end
            odaf_pkg::S_GDIV:
            begin
                if (div_done)
                begin
                    state_next = odaf_pkg::S_SCHK;
                end
            end
            odaf_pkg::S_SCHK:
            begin
                if ((td_reg == '0) || (goal_reg == now_reg))
                begin
                    state_next = odaf_pkg::S_DONE;
                end
                else
                begin
                    mul_en     = 1'b1;
                    mul_a      = odaf_pkg::COUNT_W'(acc_sel);
                    mul_b      = td_reg;
                    state_next = odaf_pkg::S_SMAG;
                end
            end
            odaf_pkg::S_SMAG:
            begin
                state_next = odaf_pkg::S_SMOVE;
            end
            odaf_pkg::S_SMOVE:
            begin
                mul_en     = 1'b1;
                mul_a      = odaf_pkg::COUNT_W'(mag_reg);
                mul_b      = td_reg;
                state_next = odaf_pkg::S_SAPPLY;
            end
            odaf_pkg::S_SAPPLY:
            begin
                state_next = odaf_pkg::S_DONE;
            end
            odaf_pkg::S_DONE:
            begin
                if (!res_valid_reg || result.ready)
                begin
                    load_res   = 1'b1;
                    state_next = odaf_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = odaf_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= odaf_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            multi_reg   <= 1'b0;
            in_max_reg  <= odaf_pkg::CFG_RESET_RATE;
            in_acc_reg  <= odaf_pkg::CFG_RESET_RATE;
            out_max_reg <= odaf_pkg::CFG_RESET_RATE;
            out_acc_reg <= odaf_pkg::CFG_RESET_RATE;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                odaf_pkg::REG_MULTI_QUERIES: multi_reg   <= cfg.wdata[0];
                odaf_pkg::REG_IN_MAX_SPEED:  in_max_reg  <= cfg.wdata;
                odaf_pkg::REG_IN_ACCEL:      in_acc_reg  <= cfg.wdata;
                odaf_pkg::REG_OUT_MAX_SPEED: out_max_reg <= cfg.wdata;
                odaf_pkg::REG_OUT_ACCEL:     out_acc_reg <= cfg.wdata;
                default:
                begin
                end
            endcase
        end
    end

    // Fade state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg   <= '0;
            goal_reg  <= '0;
            speed_reg <= '0;
        end
        else
        begin
            case (state_reg)
                odaf_pkg::S_IDLE:
                begin
                    if (accept && item.cmd)
                    begin
                        if ((goal_calc && !counts_ok) || (phase == odaf_pkg::PH_OFF))
                        begin
                            goal_reg <= '0;
                        end
                    end
                end
                odaf_pkg::S_GDIV:
                begin
                    if (div_done)
                    begin
                        goal_reg <= div_quot;
                    end
                end
                odaf_pkg::S_SCHK:
                begin
                    if ((td_reg != '0) && (goal_reg == now_reg))
                    begin
                        speed_reg <= '0;
                    end
                end
                odaf_pkg::S_SAPPLY:
                begin
                    if (move >= CW'(diff))
                    begin
                        now_reg <= goal_reg;
                    end
                    else if (up)
                    begin
                        now_reg <= now_reg + move[AW-1:0];
                    end
                    else
                    begin
                        now_reg <= now_reg - move[AW-1:0];
                    end
                    speed_reg <= up ? SW'(mag_reg) : -SW'(mag_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Item and working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            full_reg    <= item.full_count;
            part_reg    <= item.part_count;
            td_reg      <= item.time_delta;
            gr_reg      <= !item.cmd && grant.granted;
            gr_full_reg <= !item.cmd && grant.is_full;
        end
        if (state_reg == odaf_pkg::S_GDEN)
        begin
            n_reg <= mul_p[odaf_pkg::DIV_W-1:0];
        end
        if (state_reg == odaf_pkg::S_SMAG)
        begin
            mag_reg <= mag_new;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (load_res)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_granted_reg <= gr_reg;
            res_full_reg    <= gr_full_reg;
            res_now_reg     <= now_reg;
            res_goal_reg    <= goal_reg;
        end
    end

    assign result.valid         = res_valid_reg;
    assign result.query_granted = res_granted_reg;
    assign result.query_is_full = res_full_reg;
    assign result.current_alpha = res_now_reg;
    assign result.target_alpha  = res_goal_reg;

    a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
        (now_reg <= odaf_pkg::ALPHA_ONE) && (goal_reg <= odaf_pkg::ALPHA_ONE))
        else $error("alpha or target above one");

    a_div_in_seq: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == odaf_pkg::S_GDIV))
        else $error("divider finished outside target computation");

    a_item_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != odaf_pkg::S_IDLE))
        else $error("item transfer left sequencer idle");

    a_speed_dir: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == odaf_pkg::S_SAPPLY) && up) |=> !speed_reg[SW-1])
        else $error("rising fade left a negative speed");

endmodule
`default_nettype wire

FILE: dv/odaf_fade_checker.sv
// Fader channel monitor: mirrors registers, predicts each result and compares it.
module odaf_fade_checker (
    input  logic   clk,
    input  logic   rst_n,
    odaf_item_if   item,
    odaf_result_if result,
    odaf_cfg_if    cfg,
    output int     errors,
    output int     pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import odaf_pkg::*;

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic               granted;
        logic               is_full;
        logic [ALPHA_W-1:0] alpha;
        logic [ALPHA_W-1:0] goal;
    } fade_result_t;

    logic                      multi_q;
    logic [CFG_W-1:0]          in_max;
    logic [CFG_W-1:0]          in_accel;
    logic [CFG_W-1:0]          out_max;
    logic [CFG_W-1:0]          out_accel;
    phase_t                    phase;
    logic [ALPHA_W-1:0]        alpha_now;
    logic [ALPHA_W-1:0]        alpha_goal;
    logic signed [SPEED_W-1:0] speed;
    fade_result_t              results_due[$];
    int                        fails;

    // part/full ratio faded in over the first 30 samples above the floor
    function automatic logic [ALPHA_W-1:0] occlusion_goal(input logic [COUNT_W-1:0] full,
                                                          input logic [COUNT_W-1:0] part);
        logic [63:0] ratio;
        logic [63:0] fade;
        logic [63:0] num;
        logic [63:0] den;
        if (part <= SAMPLE_FLOOR || full <= SAMPLE_FLOOR)
        begin
            return '0;
        end
        ratio = (part < full) ? 64'(part) : 64'(full);
        fade  = 64'(full) - 64'(SAMPLE_FLOOR);
        if (fade > 64'(SAMPLE_SPAN))
        begin
            fade = 64'(SAMPLE_SPAN);
        end
        num = ratio * 64'(ALPHA_ONE) * fade;
        den = 64'(full) * 64'(SAMPLE_SPAN);
        return ALPHA_W'(num / den);
    endfunction

    function automatic void advance_fade(input logic [TD_W-1:0] td);
        logic [63:0] mag;
        logic [63:0] move;
        logic [63:0] gap;
        if (td == 0)
        begin
            return;
        end
        if (alpha_goal == alpha_now)
        begin
            speed = '0;
            return;
        end
        if (alpha_goal > alpha_now)
        begin
            mag = (speed > 0) ? 64'(speed) : 64'd0;
            mag = mag + ((64'(in_accel) * 64'(td)) >> 16);
            if (mag > 64'(in_max))
            begin
                mag = 64'(in_max);
            end
            move = (mag * 64'(td)) >> 16;
            gap  = 64'(alpha_goal - alpha_now);
            alpha_now = (move >= gap) ? alpha_goal : alpha_now + ALPHA_W'(move);
            speed = SPEED_W'(mag);
        end
        else
        begin
            mag = (speed < 0) ? 64'(-speed) : 64'd0;
            mag = mag + ((64'(out_accel) * 64'(td)) >> 16);
            if (mag > 64'(out_max))
            begin
                mag = 64'(out_max);
            end
            move = (mag * 64'(td)) >> 16;
            gap  = 64'(alpha_now - alpha_goal);
            alpha_now = (move >= gap) ? alpha_goal : alpha_now - ALPHA_W'(move);
            speed = SPEED_W'(0) - SPEED_W'(mag);
        end
    endfunction

    function automatic fade_result_t predict_fade(input logic cmd,
                                                  input logic full_pass,
                                                  input logic visible,
                                                  input logic results_ready,
                                                  input logic [COUNT_W-1:0] full_count,
                                                  input logic [COUNT_W-1:0] part_count,
                                                  input logic [TD_W-1:0] td);
        fade_result_t r;
        r = '0;
        if (!cmd)
        begin
            if (visible)
            begin
                if (phase == PH_OFF)
                begin
                    phase = PH_AWAIT_FULL;
                end
            end
            else
            begin
                phase = PH_OFF;
            end
            if (multi_q)
            begin
                if (phase != PH_OFF)
                begin
                    phase = PH_PENDING;
                    r.granted = 1'b1;
                end
            end
            else if (phase == PH_AWAIT_FULL)
            begin
                phase = PH_AWAIT_PART;
                r.granted = 1'b1;
            end
            else if (phase == PH_AWAIT_PART)
            begin
                phase = PH_PENDING;
                r.granted = 1'b1;
            end
            r.is_full = r.granted & full_pass;
        end
        else
        begin
            if (phase == PH_PENDING)
            begin
                if (results_ready)
                begin
                    alpha_goal = occlusion_goal(full_count, part_count);
                    if (!multi_q)
                    begin
                        phase = PH_AWAIT_FULL;
                    end
                end
            end
            else if (phase == PH_OFF)
            begin
                alpha_goal = '0;
            end
            advance_fade(td);
        end
        r.alpha = alpha_now;
        r.goal  = alpha_goal;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        fade_result_t seen;
        fade_result_t due;
        if (!rst_n)
        begin
            multi_q    = 1'b0;
            in_max     = CFG_RESET_RATE;
            in_accel   = CFG_RESET_RATE;
            out_max    = CFG_RESET_RATE;
            out_accel  = CFG_RESET_RATE;
            phase      = PH_AWAIT_FULL;
            alpha_now  = '0;
            alpha_goal = '0;
            speed      = '0;
            results_due.delete();
            fails      = 0;
            errors    <= 0;
            pending   <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_MULTI_QUERIES: multi_q   = cfg.wdata[0];
                    REG_IN_MAX_SPEED:  in_max    = cfg.wdata;
                    REG_IN_ACCEL:      in_accel  = cfg.wdata;
                    REG_OUT_MAX_SPEED: out_max   = cfg.wdata;
                    REG_OUT_ACCEL:     out_accel = cfg.wdata;
                    default: ;
                endcase
            end
            if (result.valid && result.ready)
            begin
                seen.granted = result.query_granted;
                seen.is_full = result.query_is_full;
                seen.alpha   = result.current_alpha;
                seen.goal    = result.target_alpha;
                if (results_due.size() == 0)
                begin
                    if (fails < MAX_REPORTS)
                    begin
                        $display("%0t: result transfer with nothing outstanding", $realtime);
                    end
                    fails++;
                end
                else
                begin
                    due = results_due.pop_front();
                    if (seen.granted !== due.granted || seen.is_full !== due.is_full ||
                        seen.alpha !== due.alpha || seen.goal !== due.goal)
                    begin
                        if (fails < MAX_REPORTS)
                        begin
                            $display("%0t: mismatch exp grant %0b full %0b alpha %0d goal %0d",
                                     $realtime, due.granted, due.is_full, due.alpha, due.goal);
                            $display("%0t:          got grant %0b full %0b alpha %0d goal %0d",
                                     $realtime, seen.granted, seen.is_full, seen.alpha,
                                     seen.goal);
                        end
                        fails++;
                    end
                end
            end
            if (item.valid && item.ready)
            begin
                results_due.push_back(predict_fade(item.cmd, item.full_pass, item.visible,
                                                   item.results_ready, item.full_count,
                                                   item.part_count, item.time_delta));
            end
            errors  <= fails;
            pending <= results_due.size();
        end
    end

endmodule

FILE: dv/tb_occlusion_driven_alpha_fader.sv
// Testbench top: clock, reset, item and register stimulus, result stalls and verdict.
module tb_occlusion_driven_alpha_fader;
    timeunit 1ns;
    timeprecision 1ps;

    import odaf_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int RATE_SETS      = 6;
    localparam int ITEMS_PER_SET  = 300;
    localparam int LONG_HOLD_AT   = 700;
    localparam int LONG_HOLD      = 400;
    localparam logic [CFG_W-1:0] RATE_MAX = '1;
    localparam logic [IDX_W-1:0] IDX_UNMAPPED = 3'd5;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;
    int   errors;
    int   pending;
    int   sent_items = 0;
    int   quiet_cycles = 0;
    bit   idle_on = 1'b1;
    bit   multi_mode = 1'b0;

    odaf_item_if   item_ch ();
    odaf_result_if result_ch ();
    odaf_cfg_if    cfg_ch ();

    occlusion_driven_alpha_fader dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    odaf_fade_checker fade_check (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item_ch),
        .result  (result_ch),
        .cfg     (cfg_ch),
        .errors  (errors),
        .pending (pending)
    );

    always #5 clk = ~clk;

    task automatic send_item(input logic cmd, input logic full_pass, input logic visible,
                             input logic results_ready, input logic [COUNT_W-1:0] full_count,
                             input logic [COUNT_W-1:0] part_count,
                             input logic [TD_W-1:0] td);
        int gap;
        gap = (idle_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
        repeat (gap)
        begin
            @(negedge clk);
            item_ch.valid = 1'b0;
        end
        @(negedge clk);
        item_ch.valid         = 1'b1;
        item_ch.cmd           = cmd;
        item_ch.full_pass     = full_pass;
        item_ch.visible       = visible;
        item_ch.results_ready = results_ready;
        item_ch.full_count    = full_count;
        item_ch.part_count    = part_count;
        item_ch.time_delta    = td;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        sent_items++;
    endtask

    // unused fields carry random values so that they are seen to be ignored
    task automatic draw_pass(input logic full_pass, input logic visible);
        send_item(1'b0, full_pass, visible, 1'($urandom_range(0, 1)), $urandom, $urandom,
                  TD_W'($urandom_range(0, 65535)));
    endtask

    task automatic frame_update(input logic results_ready, input logic [COUNT_W-1:0] full_count,
                                input logic [COUNT_W-1:0] part_count,
                                input logic [TD_W-1:0] td);
        send_item(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), results_ready,
                  full_count, part_count, td);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] index, input logic [CFG_W-1:0] wdata);
        @(negedge clk);
        cfg_ch.valid = 1'b1;
        cfg_ch.index = index;
        cfg_ch.wdata = wdata;
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        cfg_ch.valid = 1'b0;
    endtask

    task automatic settle();
        @(negedge clk);
        item_ch.valid = 1'b0;
        while (pending != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic apply_rates(input int set);
        logic [CFG_W-1:0] rate [4];
        case (set)
            0: rate = '{CFG_RESET_RATE, CFG_RESET_RATE, CFG_RESET_RATE, CFG_RESET_RATE};
            1: rate = '{RATE_MAX, RATE_MAX, RATE_MAX, RATE_MAX};
            2: rate = '{'0, '0, '0, '0};
            3: rate = '{24'd1000, RATE_MAX, RATE_MAX, 24'd500};
            default:
            begin
                foreach (rate[i])
                begin
                    rate[i] = ($urandom_range(0, 1) == 0) ? CFG_W'($urandom)
                                                        : CFG_W'($urandom_range(0, 400000));
                end
            end
        endcase
        multi_mode = (set == 1 || set == 3) ? 1'b1 :
                     (set == 4) ? 1'($urandom_range(0, 1)) : 1'b0;
        write_reg(REG_MULTI_QUERIES, {(CFG_W-1)'($urandom), multi_mode});
        write_reg(REG_IN_MAX_SPEED, rate[0]);
        write_reg(REG_IN_ACCEL, rate[1]);
        write_reg(REG_OUT_MAX_SPEED, rate[2]);
        write_reg(REG_OUT_ACCEL, rate[3]);
        write_reg(IDX_W'($urandom_range(IDX_UNMAPPED, (1 << IDX_W) - 1)), CFG_W'($urandom));
    endtask

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 5))
            0: return $urandom_range(0, 20);
            1: return $urandom_range(14, 50);
            2: return $urandom_range(0, 5000);
            3: return $urandom;
            4: return '1;
            default: return $urandom_range(16, 1000000);
        endcase
    endfunction

    function automatic logic [COUNT_W-1:0] pick_part(input logic [COUNT_W-1:0] full_count);
        case ($urandom_range(0, 3))
            0: return full_count;
            1: return $urandom_range(0, full_count);
            2: return full_count + $urandom_range(0, 100);
            default: return pick_count();
        endcase
    endfunction

    function automatic logic [TD_W-1:0] pick_step();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2, 3: return TD_W'($urandom_range(0, 65535));
            4, 5: return TD_W'($urandom_range(2000, 20000));
            default: return TD_W'($urandom_range(1, 2000));
        endcase
    endfunction

    task automatic random_frame();
        int kind;
        logic [COUNT_W-1:0] full_n;
        kind   = $urandom_range(0, 9);
        full_n = pick_count();
        if (kind < 8)
        begin
            if (multi_mode)
            begin
                draw_pass(1'($urandom_range(0, 1)), 1'b1);
            end
            else if (kind == 0)
            begin
                draw_pass(1'b0, 1'b1);
                draw_pass(1'b1, 1'b1);
            end
            else
            begin
                draw_pass(1'b1, 1'b1);
                draw_pass(1'b0, 1'b1);
            end
            frame_update(kind != 1, full_n, pick_part(full_n), pick_step());
            repeat ($urandom_range(0, 2))
            begin
                frame_update(1'($urandom_range(0, 1)), pick_count(), pick_count(), pick_step());
            end
        end
        else
        begin
            send_item(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), $urandom, $urandom,
                      TD_W'($urandom_range(0, 65535)));
        end
    endtask

    // result side: short random stalls plus one long hold-off to back up the input
    initial
    begin
        int stall;
        bit held;
        stall = 0;
        held  = 1'b0;
        result_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!held && sent_items >= LONG_HOLD_AT)
            begin
                held  = 1'b1;
                stall = LONG_HOLD;
            end
            else if (stall == 0 && idle_on && $urandom_range(0, 4) == 0)
            begin
                stall = $urandom_range(1, 3);
            end
            if (stall > 0)
            begin
                result_ch.ready = 1'b0;
                stall--;
            end
            else
            begin
                result_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        int target;
        item_ch.valid         = 1'b0;
        item_ch.cmd           = 1'b0;
        item_ch.full_pass     = 1'b0;
        item_ch.visible       = 1'b0;
        item_ch.results_ready = 1'b0;
        item_ch.full_count    = '0;
        item_ch.part_count    = '0;
        item_ch.time_delta    = '0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.index          = REG_MULTI_QUERIES;
        cfg_ch.wdata          = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single-query sequencing on reset rates
        frame_update(1'b1, 32'd100, 32'd100, 16'd0);
        draw_pass(1'b1, 1'b1);
        draw_pass(1'b0, 1'b1);
        draw_pass(1'b1, 1'b1);
        frame_update(1'b1, 32'd100, 32'd100, 16'd1000);
        frame_update(1'b0, '0, '0, '1);
        frame_update(1'b1, '0, '0, '0);
        draw_pass(1'b0, 1'b0);
        frame_update(1'b1, '1, '1, '1);
        draw_pass(1'b0, 1'b1);
        draw_pass(1'b1, 1'b1);
        frame_update(1'b1, 32'd16, 32'd16, 16'd3000);
        draw_pass(1'b1, 1'b1);
        draw_pass(1'b0, 1'b1);
        frame_update(1'b1, '1, '1, '1);
        draw_pass(1'b1, 1'b1);
        draw_pass(1'b0, 1'b1);
        frame_update(1'b1, 32'd15, 32'd1000, 16'd100);
        draw_pass(1'b1, 1'b1);
        draw_pass(1'b0, 1'b1);
        frame_update(1'b1, 32'd1000, '1, 16'd20000);

        // multiple-query mode: every visible pass is granted
        settle();
        multi_mode = 1'b1;
        write_reg(REG_MULTI_QUERIES, CFG_W'(1));
        draw_pass(1'b1, 1'b1);
        draw_pass(1'b0, 1'b1);
        frame_update(1'b1, 32'd46, 32'd20, 16'd500);
        draw_pass(1'b1, 1'b0);
        frame_update(1'b1, 32'd46, 32'd46, 16'd500);

        for (int set = 0; set < RATE_SETS; set++)
        begin
            settle();
            apply_rates(set);
            target = sent_items + ITEMS_PER_SET;
            while (sent_items < target)
            begin
                idle_on = (set != RATE_SETS - 1) && ((sent_items / 64) % 4 != 3);
                random_frame();
            end
        end

        settle();
        if (errors == 0 && pending == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/core/odaf_pkg.sv
rtl/core/odaf_ifs.sv
rtl/core/odaf_phase.sv
rtl/core/odaf_mul.sv
rtl/core/odaf_div.sv
rtl/core/occlusion_driven_alpha_fader.sv
dv/odaf_fade_checker.sv
dv/tb_occlusion_driven_alpha_fader.sv
